// ----- hdl/crcfd_pkg.sv -----
package crcfd_pkg;

  localparam int CFG_IW = 3;

  localparam logic [CFG_IW-1:0] REG_HEADER = 3'd0;
  localparam logic [CFG_IW-1:0] REG_FOOTER = 3'd1;
  localparam logic [CFG_IW-1:0] REG_POLY   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_INIT   = 3'd3;

  localparam logic [7:0] HEADER_RESET = 8'h02;
  localparam logic [7:0] FOOTER_RESET = 8'h03;
  localparam logic [7:0] POLY_RESET   = 8'h07;
  localparam logic [7:0] INIT_RESET   = 8'h00;

  typedef enum logic [3:0] {
    S_HEAD1,
    S_HEAD2,
    S_CMDHI,
    S_CMDLO,
    S_LEN,
    S_DATA,
    S_FOOT1,
    S_FOOT2,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic len_load;
    logic data_step;
    logic emit_start;
    logic emit_load;
    logic emit_empty;
  } cmd_t;

  typedef struct packed {
    logic hdr_match;
    logic ftr_match;
    logic byte_zero;
    logic data_done;
    logic frame_good;
    logic cnt_zero;
    logic emit_last;
    logic out_free;
  } sts_t;

  // One byte through the CRC-8 register, MSB first.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) c = {c[6:0], 1'b0} ^ poly;
      else c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ----- hdl/crcfd_ctrl.sv -----
module crcfd_ctrl
  import crcfd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   s_axis_tvalid,
  input  sts_t   sts,
  output logic   s_axis_tready,
  output cmd_t   cmd
);

  state_t state, state_next;
  logic   acc;
  logic   emit_go;

  assign s_axis_tready = (state != S_EMIT) && ((state != S_FOOT2) || sts.out_free);
  assign acc = s_axis_tvalid && s_axis_tready;
  assign emit_go = acc && (state == S_FOOT2) && sts.ftr_match && sts.frame_good;

  always_ff @(posedge clk) begin
    if (rst) state <= S_HEAD1;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_HEAD1: if (acc && sts.hdr_match) state_next = S_HEAD2;
      S_HEAD2: if (acc) state_next = sts.hdr_match ? S_CMDHI : S_HEAD1;
      S_CMDHI: if (acc) state_next = S_CMDLO;
      S_CMDLO: if (acc) state_next = S_LEN;
      S_LEN:   if (acc) state_next = sts.byte_zero ? S_FOOT1 : S_DATA;
      S_DATA:  if (acc && sts.data_done) state_next = S_FOOT1;
      S_FOOT1: if (acc) state_next = sts.ftr_match ? S_FOOT2 : S_HEAD1;
      S_FOOT2: if (acc) state_next = (emit_go && !sts.cnt_zero) ? S_EMIT : S_HEAD1;
      S_EMIT:  if (sts.out_free && sts.emit_last) state_next = S_HEAD1;
      default: state_next = S_HEAD1;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_LEN:   cmd.len_load = acc;
      S_DATA:  cmd.data_step = acc;
      S_FOOT2: begin
        cmd.emit_start = emit_go && !sts.cnt_zero;
        cmd.emit_empty = emit_go && sts.cnt_zero;
      end
      S_EMIT:  cmd.emit_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- hdl/crcfd_dp.sv -----
module crcfd_dp
  import crcfd_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic [7:0]        s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,
  output logic              m_axis_tuser,
  output logic              m_axis_tlast,
  input  cmd_t              cmd,
  output sts_t              sts
);

  localparam int AW = $clog2(MAX_PAYLOAD);
  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  logic [7:0] header_value, footer_value, crc_polynomial, crc_initial;
  logic [7:0] frame_length, byte_index, running_crc, sub_command, emit_idx;
  logic       crc_ok, overflow_flag;
  logic [7:0] mem [MAX_PAYLOAD];
  logic [7:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic       rd_en, in_range;
  logic [7:0] cnt;
  logic [7:0] emit_idx_next;

  logic [7:0] out_sub, out_byte;
  logic [5:0] out_count;
  logic       out_dv, out_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_value   <= HEADER_RESET;
      footer_value   <= FOOTER_RESET;
      crc_polynomial <= POLY_RESET;
      crc_initial    <= INIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HEADER: header_value   <= cfg_data;
        REG_FOOTER: footer_value   <= cfg_data;
        REG_POLY:   crc_polynomial <= cfg_data;
        REG_INIT:   crc_initial    <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign in_range      = byte_index < MAX_LEN;
  assign cnt           = frame_length - 8'd2;
  assign emit_idx_next = emit_idx + 8'd1;
  assign rd_en         = cmd.emit_start || cmd.emit_load;
  assign rd_addr       = cmd.emit_start ? AW'(1) : emit_idx_next[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length  <= 8'd0;
      byte_index    <= 8'd0;
      running_crc   <= INIT_RESET;
      crc_ok        <= 1'b0;
      overflow_flag <= 1'b0;
      emit_idx      <= 8'd0;
    end else begin
      if (cmd.len_load) begin
        frame_length  <= s_axis_tdata;
        byte_index    <= 8'd0;
        running_crc   <= crc_initial;
        crc_ok        <= 1'b0;
        overflow_flag <= 1'b0;
      end
      if (cmd.data_step) begin
        if (!in_range) overflow_flag <= 1'b1;
        // The latest byte checks against the CRC of everything before it.
        crc_ok      <= (s_axis_tdata == running_crc);
        running_crc <= crc8_step(running_crc, s_axis_tdata, crc_polynomial);
        byte_index  <= byte_index + 8'd1;
      end
      if (cmd.emit_start) emit_idx <= 8'd1;
      else if (cmd.emit_load) emit_idx <= emit_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.data_step && byte_index == 8'd0) sub_command <= s_axis_tdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.data_step && in_range) mem[byte_index[AW-1:0]] <= s_axis_tdata;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (cmd.emit_load || cmd.emit_empty) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_sub   <= sub_command;
      out_byte  <= rd_data;
      out_dv    <= 1'b1;
      out_count <= cnt[5:0];
      out_last  <= (emit_idx == cnt);
    end else if (cmd.emit_empty) begin
      out_sub   <= sub_command;
      out_byte  <= 8'd0;
      out_dv    <= 1'b0;
      out_count <= 6'd0;
      out_last  <= 1'b1;
    end
  end

  assign m_axis_tdata = {2'b00, out_count, out_byte, out_sub};
  assign m_axis_tuser = out_dv;
  assign m_axis_tlast = out_last;

  always_comb begin
    sts.hdr_match  = (s_axis_tdata == header_value);
    sts.ftr_match  = (s_axis_tdata == footer_value);
    sts.byte_zero  = (s_axis_tdata == 8'd0);
    sts.data_done  = ({1'b0, byte_index} + 9'd1) >= {1'b0, frame_length};
    sts.frame_good = (frame_length >= 8'd2) && (frame_length <= MAX_LEN) &&
                     !overflow_flag && crc_ok;
    sts.cnt_zero   = (frame_length == 8'd2);
    sts.emit_last  = (emit_idx == cnt);
    sts.out_free   = !m_axis_tvalid || m_axis_tready;
  end

endmodule

// ----- hdl/crc8_frame_deframer.sv -----
// Channel   Dir  Handshake               Word
// --------  ---  ----------------------  ----------------------------------------------
// s_axis    in   s_axis_tvalid/tready    tdata[7:0] received byte
// m_axis    out  m_axis_tvalid/tready    tdata sub_command/data_byte/data_count,
//                                        tuser data_valid, tlast end of frame run
// cfg       in   cfg_valid/cfg_ready     cfg_index register, cfg_data value
//
// Parsing takes one byte per cycle while tready is high; cfg_ready is always high.
// A good frame emits its run after the second footer: one word per cycle while
// the sink takes them, set by the single read port of the payload memory, whose
// read data is registered ahead of the output register. Input is held off until
// the last word of the run sits in the output register.
// The second footer byte waits while the output register holds an untaken word.
// Reset is synchronous and clears the parser, frame counters, output valid and
// the registers to their defaults; the payload memory is never cleared.
module crc8_frame_deframer
  import crcfd_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,   // [7:0] sub_command, [15:8] data_byte,
                                            // [21:16] data_count, [23:22] zero
  output logic              m_axis_tuser,   // [0] data_valid
  output logic              m_axis_tlast,   // last word of the frame run
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [7:0]        cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // Parser and emit sequencing
  crcfd_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .sts           (sts),
    .s_axis_tready (s_axis_tready),
    .cmd           (cmd)
  );

  // Registers, CRC, payload memory and output word
  crcfd_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cmd           (cmd),
    .sts           (sts)
  );

  // Never overwrite a word the sink has not taken.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_load || cmd.emit_empty) |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output word overwritten while stalled");

  // Hold off input bytes while a run is being read out.
  a_no_input_in_run: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> !s_axis_tready)
    else $error("input accepted during run");

  // A word without data is the only word of its frame.
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata[21:8] == 14'd0))
    else $error("empty word malformed");

endmodule
